@@ src/two_row_char_display_buffer_unit_defines.svh @@
// assertion macros for the two-row character display buffer
`ifndef TWO_ROW_CHAR_DISPLAY_BUFFER_UNIT_DEFINES_SVH
`define TWO_ROW_CHAR_DISPLAY_BUFFER_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF
// same-cycle implication
`define TCDB_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tcdb assertion failed");
// next-cycle implication
`define TCDB_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tcdb assertion failed");
`else
`define TCDB_ASSERT_IMPL(lbl, clk, rst, ante, cons)
`define TCDB_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

@@ src/tcdb_pkg.sv @@
// shared constants, types and character functions of the display buffer
`default_nettype none
package tcdb_pkg;

  localparam int COLUMNS_DEF = 16;
  localparam int ROWS        = 2;

  localparam int MODE_W  = 3;
  localparam int BYTE_W  = 8;
  localparam int COL_O_W = 4;
  localparam int CFG_I_W = 1;

  localparam logic [MODE_W-1:0] MODE_PUT    = 3'd0;
  localparam logic [MODE_W-1:0] MODE_CLEAR  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_GOTO   = 3'd2;
  localparam logic [MODE_W-1:0] MODE_CLREND = 3'd3;
  localparam logic [MODE_W-1:0] MODE_HEX    = 3'd4;
  localparam logic [MODE_W-1:0] MODE_READ   = 3'd5;

  localparam logic [CFG_I_W-1:0] CFG_EXP     = 1'b0;
  localparam logic [CFG_I_W-1:0] CFG_EXP_NEG = 1'b1;

  localparam logic [BYTE_W-1:0] EXP_RESET     = 8'd1;
  localparam logic [BYTE_W-1:0] EXP_NEG_RESET = 8'd2;

  localparam logic [BYTE_W-1:0] CODE_TAB   = 8'd9;
  localparam logic [BYTE_W-1:0] CODE_LF    = 8'd10;
  localparam logic [BYTE_W-1:0] CODE_CR    = 8'd13;
  localparam logic [BYTE_W-1:0] CHAR_SPACE = 8'h20;
  localparam logic [BYTE_W-1:0] CHAR_DASH  = 8'h2d;
  localparam logic [BYTE_W-1:0] CHAR_DOT   = 8'h2e;
  localparam logic [BYTE_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [BYTE_W-1:0] CHAR_NINE  = 8'h39;
  localparam logic [BYTE_W-1:0] CHAR_E     = 8'h45;
  localparam logic [BYTE_W-1:0] CHAR_CARET = 8'h5e;
  localparam logic [BYTE_W-1:0] CHAR_LA    = 8'h61;

  typedef struct packed {
    logic exec;       // input transaction accepted this cycle
    logic clr_step;   // blank one cell at the cursor and advance
    logic rd_done;    // read data of the cell RAM is valid
    logic load_out;   // result goes to the output register
    logic load_pend;  // result goes to the pending register
    logic move_pend;  // pending result moves to the output register
  } cmd_t;

  typedef struct packed {
    logic is_read;    // offered transaction reads a cell
    logic clr_start;  // offered transaction starts blanking the row end
    logic clr_last;   // cursor sits on the last column
  } stat_t;

  function automatic logic [BYTE_W-1:0] hex_char(input logic [3:0] nib);
    logic [BYTE_W-1:0] n;
    n = {4'b0, nib};
    if (nib <= 4'd9) begin
      return CHAR_ZERO + n;
    end
    return CHAR_LA + n - 8'd10;
  endfunction

  function automatic logic [BYTE_W-1:0] map_char(input logic [BYTE_W-1:0] c,
                                                 input logic [BYTE_W-1:0] e,
                                                 input logic [BYTE_W-1:0] en);
    if (c == e) begin
      return CHAR_E;
    end
    if (c == en) begin
      return CHAR_DASH;
    end
    return c;
  endfunction

  function automatic logic char_ok(input logic [BYTE_W-1:0] c,
                                   input logic [BYTE_W-1:0] e,
                                   input logic [BYTE_W-1:0] en);
    return (c >= CHAR_ZERO && c <= CHAR_NINE) || c == e || c == en ||
           c == CHAR_DOT || c == CHAR_SPACE || c == CHAR_DASH || c == CHAR_CARET;
  endfunction

endpackage
`default_nettype wire

@@ src/tcdb_req_if.sv @@
// request channel of the display buffer
`default_nettype none
interface tcdb_req_if;
  logic                            valid;
  logic                            ready;
  logic [tcdb_pkg::MODE_W-1:0]     mode;
  logic [tcdb_pkg::BYTE_W-1:0]     char_code;
  logic [tcdb_pkg::BYTE_W-1:0]     target_row;
  logic [tcdb_pkg::BYTE_W-1:0]     target_col;
  logic [tcdb_pkg::BYTE_W-1:0]     clear_row;
  logic [tcdb_pkg::BYTE_W-1:0]     nibble_value;

  modport source (output valid, mode, char_code, target_row, target_col, clear_row,
                  nibble_value, input ready);
  modport sink (input valid, mode, char_code, target_row, target_col, clear_row,
                nibble_value, output ready);
endinterface
`default_nettype wire

@@ src/tcdb_rsp_if.sv @@
// result channel of the display buffer
`default_nettype none
interface tcdb_rsp_if;
  logic                             valid;
  logic                             ready;
  logic                             cursor_row_out;
  logic [tcdb_pkg::COL_O_W-1:0]     cursor_col_out;
  logic [tcdb_pkg::BYTE_W-1:0]      read_char;
  logic                             invalid_char;
  logic                             range_error;

  modport source (output valid, cursor_row_out, cursor_col_out, read_char, invalid_char,
                  range_error, input ready);
  modport sink (input valid, cursor_row_out, cursor_col_out, read_char, invalid_char,
                range_error, output ready);
endinterface
`default_nettype wire

@@ src/tcdb_cfg_if.sv @@
// register write channel of the display buffer
`default_nettype none
interface tcdb_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [tcdb_pkg::CFG_I_W-1:0]     index;
  logic [tcdb_pkg::BYTE_W-1:0]      data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

@@ src/tcdb_ram.sv @@
// generic simple dual-port RAM with registered read
`default_nettype none
module tcdb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

@@ src/tcdb_ctrl.sv @@
// controller: transaction sequencing and result register handoff
`default_nettype none
module tcdb_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            req_valid,
  output logic                 req_ready,
  output logic                 rsp_valid,
  input  wire logic            rsp_ready,
  input  wire tcdb_pkg::stat_t st,
  output tcdb_pkg::cmd_t       cmd
);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_READ  = 3'b010,
    S_CLEAR = 3'b100
  } state_t;

  state_t state, state_next;
  logic   pend_valid, pend_valid_next;
  logic   rsp_valid_next;
  logic   accept, done, out_free;

  assign req_ready = (state == S_IDLE) && !pend_valid;
  assign accept    = req_valid && req_ready;
  assign out_free  = !rsp_valid || rsp_ready;

  always_comb begin
    state_next = state;
    done       = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (st.is_read) begin
            state_next = S_READ;
          end else if (st.clr_start) begin
            state_next = S_CLEAR;
          end else begin
            done = 1'b1;
          end
        end
      end
      S_READ: begin
        state_next = S_IDLE;
        done       = 1'b1;
      end
      S_CLEAR: begin
        if (st.clr_last) begin
          state_next = S_IDLE;
          done       = 1'b1;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd.exec      = accept;
    cmd.clr_step  = (state == S_CLEAR);
    cmd.rd_done   = (state == S_READ);
    cmd.move_pend = pend_valid && out_free;
    // a new result can only appear while nothing is pending
    cmd.load_out  = done && out_free && !pend_valid;
    cmd.load_pend = done && !out_free;
  end

  always_comb begin
    rsp_valid_next = out_free ? (cmd.move_pend || cmd.load_out) : 1'b1;
    priority if (cmd.load_pend) begin
      pend_valid_next = 1'b1;
    end else if (cmd.move_pend) begin
      pend_valid_next = 1'b0;
    end else begin
      pend_valid_next = pend_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      pend_valid <= 1'b0;
      rsp_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      pend_valid <= pend_valid_next;
      rsp_valid  <= rsp_valid_next;
    end
  end

endmodule
`default_nettype wire

@@ src/tcdb_dp.sv @@
// datapath: cursor, cell RAM with valid flags, registers and result registers
`default_nettype none
module tcdb_dp #(
  parameter int COLUMNS = tcdb_pkg::COLUMNS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic [tcdb_pkg::MODE_W-1:0]     mode,
  input  wire logic [tcdb_pkg::BYTE_W-1:0]     char_code,
  input  wire logic [tcdb_pkg::BYTE_W-1:0]     target_row,
  input  wire logic [tcdb_pkg::BYTE_W-1:0]     target_col,
  input  wire logic [tcdb_pkg::BYTE_W-1:0]     clear_row,
  input  wire logic [tcdb_pkg::BYTE_W-1:0]     nibble_value,
  input  wire logic                            cfg_we,
  input  wire logic [tcdb_pkg::CFG_I_W-1:0]    cfg_index,
  input  wire logic [tcdb_pkg::BYTE_W-1:0]     cfg_data,
  input  wire tcdb_pkg::cmd_t                  cmd,
  output tcdb_pkg::stat_t                      st,
  output logic                                 cursor_row_out,
  output logic [tcdb_pkg::COL_O_W-1:0]         cursor_col_out,
  output logic [tcdb_pkg::BYTE_W-1:0]          read_char,
  output logic                                 invalid_char,
  output logic                                 range_error
);

  localparam int CW    = $clog2(COLUMNS);
  localparam int CELLS = tcdb_pkg::ROWS * COLUMNS;
  localparam int AW    = $clog2(CELLS);
  localparam int BW    = tcdb_pkg::BYTE_W;
  localparam logic [CW-1:0] LAST_COL = CW'(COLUMNS - 1);

  logic [BW-1:0]   exp_code, exp_neg_code;
  logic            cur_row, cur_row_next;
  logic [CW-1:0]   cur_col, cur_col_next;
  logic [CELLS-1:0] cell_valid, cell_valid_next;
  logic            rd_rerr, rd_vld;
  logic [BW-1:0]   rdata;

  logic [BW-1:0]   c_in, wdata;
  logic            is_put, clear_all, crlf, tab, pos_ok;
  logic            pre_row, w_row, adv_row;
  logic [CW-1:0]   pre_col, w_col, adv_col;
  logic            we;
  logic [AW-1:0]   waddr, raddr;
  logic [BW-1:0]   rd_val;

  logic            res_row;
  logic [tcdb_pkg::COL_O_W-1:0] res_col;
  logic [BW-1:0]   res_rd;
  logic            res_bad, res_rerr;

  logic            pend_row;
  logic [tcdb_pkg::COL_O_W-1:0] pend_col;
  logic [BW-1:0]   pend_rd;
  logic            pend_bad, pend_rerr;

  // decode of the offered transaction
  always_comb begin
    c_in = (mode == tcdb_pkg::MODE_HEX) ? tcdb_pkg::hex_char(nibble_value[3:0]) : char_code;
    is_put    = cmd.exec && (mode == tcdb_pkg::MODE_PUT || mode == tcdb_pkg::MODE_HEX);
    crlf      = (c_in == tcdb_pkg::CODE_CR) || (c_in == tcdb_pkg::CODE_LF);
    tab       = (c_in == tcdb_pkg::CODE_TAB);
    clear_all = cmd.exec && (mode == tcdb_pkg::MODE_CLEAR ||
                             (mode == tcdb_pkg::MODE_PUT && crlf));
    pos_ok    = (target_row < BW'(tcdb_pkg::ROWS)) && (target_col < BW'(COLUMNS));
  end

  // cursor move before the write: home on line end, other row on tab
  always_comb begin
    priority if (crlf) begin
      pre_row = 1'b0;
      pre_col = '0;
    end else if (tab) begin
      pre_row = !cur_row;
      pre_col = '0;
    end else begin
      pre_row = cur_row;
      pre_col = cur_col;
    end
  end

  always_comb begin
    if (cmd.clr_step) begin
      w_row = cur_row;
      w_col = cur_col;
      wdata = tcdb_pkg::map_char(tcdb_pkg::CHAR_SPACE, exp_code, exp_neg_code);
    end else begin
      w_row = pre_row;
      w_col = pre_col;
      wdata = tcdb_pkg::map_char(c_in, exp_code, exp_neg_code);
    end
    if (w_col == LAST_COL) begin
      adv_row = !w_row;
      adv_col = '0;
    end else begin
      adv_row = w_row;
      adv_col = w_col + CW'(1);
    end
    we    = is_put || cmd.clr_step;
    waddr = w_row ? AW'(COLUMNS) + AW'(w_col) : AW'(w_col);
    raddr = target_row[0] ? AW'(COLUMNS) + AW'(target_col[CW-1:0])
                          : AW'(target_col[CW-1:0]);
  end

  always_comb begin
    cur_row_next = cur_row;
    cur_col_next = cur_col;
    if (cmd.exec) begin
      unique case (mode)
        tcdb_pkg::MODE_PUT, tcdb_pkg::MODE_HEX: begin
          cur_row_next = adv_row;
          cur_col_next = adv_col;
        end
        tcdb_pkg::MODE_CLEAR: begin
          cur_row_next = 1'b0;
          cur_col_next = '0;
        end
        tcdb_pkg::MODE_GOTO: begin
          if (pos_ok) begin
            cur_row_next = target_row[0];
            cur_col_next = target_col[CW-1:0];
          end
        end
        default: begin
        end
      endcase
    end else if (cmd.clr_step) begin
      cur_row_next = adv_row;
      cur_col_next = adv_col;
    end
  end

  // a cell without its valid flag reads as a space
  always_comb begin
    for (int i = 0; i < CELLS; i++) begin
      cell_valid_next[i] = (clear_all ? 1'b0 : cell_valid[i]) || (we && waddr == AW'(i));
    end
  end

  tcdb_ram #(
    .WIDTH (BW),
    .DEPTH (CELLS)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    if (rd_rerr) begin
      rd_val = '0;
    end else begin
      rd_val = rd_vld ? rdata : tcdb_pkg::CHAR_SPACE;
    end
    res_row  = cur_row_next;
    res_col  = tcdb_pkg::COL_O_W'(cur_col_next);
    res_rd   = cmd.rd_done ? rd_val : '0;
    res_bad  = is_put && !tcdb_pkg::char_ok(c_in, exp_code, exp_neg_code);
    res_rerr = (cmd.exec && mode == tcdb_pkg::MODE_GOTO && !pos_ok) ||
               (cmd.rd_done && rd_rerr);
  end

  always_comb begin
    st.is_read   = (mode == tcdb_pkg::MODE_READ);
    st.clr_start = (mode == tcdb_pkg::MODE_CLREND) && (cur_col != '0) &&
                   ({{(BW-1){1'b0}}, cur_row} == clear_row);
    st.clr_last  = (cur_col == LAST_COL);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      exp_code     <= tcdb_pkg::EXP_RESET;
      exp_neg_code <= tcdb_pkg::EXP_NEG_RESET;
      cur_row      <= 1'b0;
      cur_col      <= '0;
      cell_valid   <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          tcdb_pkg::CFG_EXP:     exp_code     <= cfg_data;
          tcdb_pkg::CFG_EXP_NEG: exp_neg_code <= cfg_data;
          default: begin
          end
        endcase
      end
      cur_row    <= cur_row_next;
      cur_col    <= cur_col_next;
      cell_valid <= cell_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec && mode == tcdb_pkg::MODE_READ) begin
      rd_rerr <= !pos_ok;
      rd_vld  <= cell_valid[raddr];
    end
    if (cmd.load_pend) begin
      pend_row  <= res_row;
      pend_col  <= res_col;
      pend_rd   <= res_rd;
      pend_bad  <= res_bad;
      pend_rerr <= res_rerr;
    end
    if (cmd.move_pend) begin
      cursor_row_out <= pend_row;
      cursor_col_out <= pend_col;
      read_char      <= pend_rd;
      invalid_char   <= pend_bad;
      range_error    <= pend_rerr;
    end else if (cmd.load_out) begin
      cursor_row_out <= res_row;
      cursor_col_out <= res_col;
      read_char      <= res_rd;
      invalid_char   <= res_bad;
      range_error    <= res_rerr;
    end
  end

endmodule
`default_nettype wire

@@ src/two_row_char_display_buffer_unit.sv @@
// Two-row character display buffer with cursor. Put char, hex nibble, clear,
// go to and the unused mode codes finish in the idle state that accepts them;
// read cell goes through the read state because the cell RAM has a registered
// read port; clear to row end blanks one cell in each step of the clear
// state, since the RAM accepts one write per cycle. Clear and line end reset
// per-cell valid flags at once, so reset needs no clearing pass. A finished
// result waits in the output register and a second one in a pending register,
// so the next transaction is taken while the result channel stalls once.
`default_nettype none
`include "two_row_char_display_buffer_unit_defines.svh"
module two_row_char_display_buffer_unit #(
  parameter int COLUMNS = tcdb_pkg::COLUMNS_DEF
) (
  input  wire logic   clk,
  input  wire logic   rst,
  tcdb_req_if.sink    req,
  tcdb_rsp_if.source  rsp,
  tcdb_cfg_if.sink    cfg
);

  tcdb_pkg::cmd_t  cmd;
  tcdb_pkg::stat_t st;

  assign cfg.ready = 1'b1;

  tcdb_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .st        (st),
    .cmd       (cmd)
  );

  tcdb_dp #(
    .COLUMNS (COLUMNS)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .mode           (req.mode),
    .char_code      (req.char_code),
    .target_row     (req.target_row),
    .target_col     (req.target_col),
    .clear_row      (req.clear_row),
    .nibble_value   (req.nibble_value),
    .cfg_we         (cfg.valid),
    .cfg_index      (cfg.index),
    .cfg_data       (cfg.data),
    .cmd            (cmd),
    .st             (st),
    .cursor_row_out (rsp.cursor_row_out),
    .cursor_col_out (rsp.cursor_col_out),
    .read_char      (rsp.read_char),
    .invalid_char   (rsp.invalid_char),
    .range_error    (rsp.range_error)
  );

  // output and pending loads never collide
  `TCDB_ASSERT_IMPL(a_load_excl, clk, rst, cmd.load_out, !cmd.load_pend && !cmd.move_pend)
  // a parked result holds off new requests
  `TCDB_ASSERT_NEXT(a_pend_blocks, clk, rst, cmd.load_pend, !req.ready)
  // pending result moves only into a free output register
  `TCDB_ASSERT_IMPL(a_move_room, clk, rst, cmd.move_pend, !rsp.valid || rsp.ready)

endmodule
`default_nettype wire
